// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the RTL files of the mask class assigner.
// No dependencies; take it in by `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define MMCA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clock edge, held off while reset is low.
`define MMCA_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== hdl/mmca_pkg.sv =====
// Shared constants for the membership mask class assigner.
// No dependencies; used by the channel interfaces and the RTL modules.
`default_nettype none

package mmca_pkg;

  // Width of one domain id on the request channel.
  localparam int ID_W = 4;

  // Width of the class index on the result channel.
  localparam int CLASS_W = 4;

  // Width used when comparing a domain id against a mask bit position.
  localparam int ID_CMP_W = 8;

endpackage

`default_nettype wire

// ===== hdl/mmca_if.sv =====
// Valid/ready channel interfaces for domain-id requests and class results.
// Depends on mmca_pkg for the field widths.
`default_nettype none

interface mmca_in_if;
  import mmca_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   domain_id;
  logic              has_domain;
  logic              last_domain;

  modport source (output valid, output domain_id, output has_domain, output last_domain,
                  input ready);
  modport sink   (input valid, input domain_id, input has_domain, input last_domain,
                  output ready);
endinterface

interface mmca_out_if;
  import mmca_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] class_index;
  logic               is_new;
  logic               table_full;

  modport source (output valid, output class_index, output is_new, output table_full,
                  input ready);
  modport sink   (input valid, input class_index, input is_new, input table_full,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/membership_mask_class_assigner_top.sv =====
// Path: a list end's mask passes the two-entry queue and then the table search, which
// ends on a hit at entry k, a miss over n >= 1 stored masks or an empty table.
// Throughput: one domain id per cycle while the two-entry queue has room; the search
// takes a new list end only once the last result is taken, reading one entry per cycle.
// Reset: asynchronous, active low; clears the pending mask, the queue and the entry count.
// Top level of the membership mask class assigner; depends on mmca_pkg and mmca_if.
`default_nettype none

module membership_mask_class_assigner_top #(
  parameter int NUM_DOMAINS = 16,
  parameter int MAX_CLASSES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mmca_in_if.sink     in_i,
  mmca_out_if.source  out_o
);
  import mmca_pkg::*;

  logic                   push_valid;
  logic                   push_ready;
  logic [NUM_DOMAINS-1:0] push_mask;
  logic                   pop_valid;
  logic                   pop_ready;
  logic [NUM_DOMAINS-1:0] pop_mask;

  // Merge ids into masks
  mmca_front #(
    .NUM_DOMAINS(NUM_DOMAINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .domain_id_i  (in_i.domain_id),
    .has_domain_i (in_i.has_domain),
    .last_domain_i(in_i.last_domain),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_mask_o  (push_mask)
  );

  // Queue finished masks
  mmca_fifo #(
    .WIDTH(NUM_DOMAINS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_mask),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_mask)
  );

  // Search, append and answer
  mmca_back #(
    .NUM_DOMAINS(NUM_DOMAINS),
    .MAX_CLASSES(MAX_CLASSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_mask_i   (pop_mask),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .class_index_o(out_o.class_index),
    .is_new_o     (out_o.is_new),
    .table_full_o (out_o.table_full)
  );

endmodule

`default_nettype wire

// ===== hdl/mmca_front.sv =====
// Front end: merges domain ids into a pending membership mask per item.
// Depends on mmca_pkg; hands each finished mask to the queue.
`default_nettype none

module mmca_front #(
  parameter int NUM_DOMAINS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mmca_pkg::ID_W-1:0]   domain_id_i,
  input  wire logic                        has_domain_i,
  input  wire logic                        last_domain_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output logic [NUM_DOMAINS-1:0]           push_mask_o
);
  import mmca_pkg::*;

  logic [NUM_DOMAINS-1:0] pending_q;
  logic [NUM_DOMAINS-1:0] pending_d;
  logic [NUM_DOMAINS-1:0] id_bit;

  // Decode the id into a mask bit; ids beyond the domain count set nothing
  always_comb begin
    for (int b = 0; b < NUM_DOMAINS; b++) begin
      id_bit[b] = has_domain_i && (ID_CMP_W'(domain_id_i) == ID_CMP_W'(b));
    end
  end

  assign pending_d    = pending_q | id_bit;
  assign push_mask_o  = pending_d;
  assign push_valid_o = in_valid_i && last_domain_i;
  assign in_ready_o   = push_ready_i;

  // Accumulate the mask; clear it once the list end has been queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      if (last_domain_i) begin
        pending_q <= '0;
      end else begin
        pending_q <= pending_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmca_fifo.sv =====
// Two-entry queue that decouples the mask front end from the table search.
// Depends on assert_macros.svh for its checks.
`default_nettype none

module mmca_fifo #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);
  `include "assert_macros.svh"

  localparam int Depth = 2;

  logic [WIDTH-1:0] slot_q [Depth];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store the incoming mask
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  `MMCA_ASSERT(a_fifo_level, clk_i, rst_ni, count_q <= 2'(Depth), "queue level beyond depth")

endmodule

`default_nettype wire

// ===== hdl/mmca_back.sv =====
// Back end: searches the mask table entry by entry, appends on a miss if there is room and
// holds the result. Depends on mmca_pkg and assert_macros.svh.
`default_nettype none

module mmca_back #(
  parameter int NUM_DOMAINS = 16,
  parameter int MAX_CLASSES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         pop_valid_i,
  output logic                              pop_ready_o,
  input  wire logic [NUM_DOMAINS-1:0]       pop_mask_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [mmca_pkg::CLASS_W-1:0]      class_index_o,
  output logic                              is_new_o,
  output logic                              table_full_o
);
  import mmca_pkg::*;
  `include "assert_macros.svh"

  localparam int IdxW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CntW = $clog2(MAX_CLASSES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                 state_q;
  logic [NUM_DOMAINS-1:0] mask_table [MAX_CLASSES];
  logic [NUM_DOMAINS-1:0] rd_data_q;
  logic [NUM_DOMAINS-1:0] cur_mask_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        rd_addr_q;
  logic [CntW-1:0]        cmp_idx_q;
  logic                   cmp_vld_q;
  logic                   res_vld_q;
  logic [CLASS_W-1:0]     res_idx_q;
  logic                   res_new_q;
  logic                   res_full_q;
  logic                   hit;
  logic                   miss;
  logic                   issue;
  logic                   has_room;
  logic                   wr_en;

  // Compare the entry read last cycle; a miss once every entry has been compared
  always_comb begin
    hit      = (state_q == ST_SCAN) && cmp_vld_q && (rd_data_q == cur_mask_q);
    miss     = (state_q == ST_SCAN) && !cmp_vld_q && (rd_addr_q == cnt_q);
    issue    = (state_q == ST_SCAN) && !hit && (rd_addr_q != cnt_q);
    has_room = (cnt_q != CntW'(MAX_CLASSES));
    wr_en    = miss && has_room;
  end

  assign pop_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o   = res_vld_q;
  assign class_index_o = res_idx_q;
  assign is_new_o      = res_new_q;
  assign table_full_o  = res_full_q;

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mask_table[cnt_q[IdxW-1:0]] <= cur_mask_q;
    end
    rd_data_q <= mask_table[rd_addr_q[IdxW-1:0]];
  end

  // Sequence the search and hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_mask_q <= '0;
      cnt_q      <= '0;
      rd_addr_q  <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      res_vld_q  <= 1'b0;
      res_idx_q  <= '0;
      res_new_q  <= 1'b0;
      res_full_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            cur_mask_q <= pop_mask_i;
            rd_addr_q  <= '0;
            cmp_vld_q  <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_idx_q  <= CLASS_W'(cmp_idx_q);
            res_new_q  <= 1'b0;
            res_full_q <= 1'b0;
            res_vld_q  <= 1'b1;
            state_q    <= ST_RESP;
          end else if (miss) begin
            if (has_room) begin
              res_idx_q  <= CLASS_W'(cnt_q);
              res_new_q  <= 1'b1;
              res_full_q <= 1'b0;
              cnt_q      <= cnt_q + 1'b1;
            end else begin
              res_idx_q  <= '0;
              res_new_q  <= 1'b0;
              res_full_q <= 1'b1;
            end
            res_vld_q <= 1'b1;
            state_q   <= ST_RESP;
          end else begin
            cmp_vld_q <= issue;
            cmp_idx_q <= rd_addr_q;
            if (issue) begin
              rd_addr_q <= rd_addr_q + 1'b1;
            end
          end
        end
        ST_RESP: begin
          if (out_ready_i) begin
            res_vld_q <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MMCA_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MAX_CLASSES), "entry count beyond table size")
  `MMCA_ASSERT_IMP(a_new_grows, clk_i, rst_ni, $rose(res_vld_q) && res_new_q, cnt_q == CntW'($past(cnt_q) + 1'b1), "new entry without count step")
  `MMCA_ASSERT_IMP(a_full_result, clk_i, rst_ni, res_vld_q && res_full_q, !res_new_q && (res_idx_q == '0) && !has_room, "full result malformed")
  `MMCA_ASSERT_IMP(a_result_held, clk_i, rst_ni, res_vld_q && !out_ready_i, ##1 res_vld_q && $stable(res_idx_q), "result dropped while stalled")

endmodule

`default_nettype wire

// ===== bench/mmca_checker.sv =====
// Scoreboard for the membership mask class assigner: watches both channels,
// keeps its own class table and compares every result. Depends on mmca_pkg and mmca_if.
`default_nettype none

module mmca_checker
  import mmca_pkg::*;
#(
  parameter int NUM_DOMAINS = 16,
  parameter int MAX_CLASSES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mmca_in_if          in_mon,
  mmca_out_if         out_mon,
  output int unsigned errors_o,
  output int unsigned due_o
);

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic               is_new;
    logic               table_full;
  } class_result_t;

  logic [NUM_DOMAINS-1:0] merged_mask;
  logic [NUM_DOMAINS-1:0] class_masks [MAX_CLASSES];
  int unsigned            class_count;
  class_result_t          classes_due [$];
  int unsigned            mismatch_count = 0;

  // Print one line per mismatch and count it.
  task automatic report(input string what);
    $display("checker: %s at %0t", what, $time);
    mismatch_count++;
  endtask

  // Compare finished results first, then fold the new request into the table copy.
  always @(posedge clk_i or negedge rst_ni) begin : track_classes
    class_result_t got;
    class_result_t want;
    logic          hit;
    int unsigned   slot;
    if (!rst_ni) begin
      merged_mask = '0;
      class_count = 0;
      classes_due.delete();
      due_o    <= 0;
      errors_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.class_index, out_mon.is_new, out_mon.table_full};
        if (classes_due.size() == 0) begin
          report($sformatf("result idx=%0d new=%0b full=%0b with none due",
                           got.class_index, got.is_new, got.table_full));
        end else begin
          want = classes_due.pop_front();
          if (got.class_index !== want.class_index)
            report($sformatf("class_index %0d, expected %0d", got.class_index,
                             want.class_index));
          if (got.is_new !== want.is_new)
            report($sformatf("is_new %0b, expected %0b", got.is_new, want.is_new));
          if (got.table_full !== want.table_full)
            report($sformatf("table_full %0b, expected %0b", got.table_full,
                             want.table_full));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        // Merge the id; ids beyond the domain count set nothing
        if (in_mon.has_domain && int'(in_mon.domain_id) < NUM_DOMAINS)
          merged_mask[in_mon.domain_id] = 1'b1;
        if (in_mon.last_domain) begin
          // Search from entry 0 upward, first match wins
          hit  = 1'b0;
          slot = 0;
          for (int k = 0; k < MAX_CLASSES; k++) begin
            if (!hit && k < class_count && class_masks[k] == merged_mask) begin
              hit  = 1'b1;
              slot = k;
            end
          end
          if (hit) begin
            want = '{CLASS_W'(slot), 1'b0, 1'b0};
          end else if (class_count < MAX_CLASSES) begin
            class_masks[class_count] = merged_mask;
            want = '{CLASS_W'(class_count), 1'b1, 1'b0};
            class_count++;
          end else begin
            // Table full: report it and leave the table alone
            want = '{CLASS_W'(0), 1'b0, 1'b1};
          end
          classes_due.insert(classes_due.size(), want);
          merged_mask = '0;
        end
      end

      due_o    <= classes_due.size();
      errors_o <= mismatch_count;
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Stimulus and verdict for the membership mask class assigner: drives domain-id
// requests and result stalls. Depends on mmca_pkg, mmca_if, mmca_checker and the RTL top.
`default_nettype none

module testbench;
  import mmca_pkg::*;

  localparam int NUM_DOMAINS     = 16;
  localparam int MAX_CLASSES     = 16;
  localparam int DIRECTED_COUNT  = 25;
  localparam int RANDOM_COUNT    = 1300;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int DRAIN_CYCLES    = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches;
  int unsigned results_due;

  // Masks stored by the directed part, in table order
  logic [NUM_DOMAINS-1:0] known_masks [MAX_CLASSES];

  mmca_in_if  in_ch ();
  mmca_out_if out_ch ();

  membership_mask_class_assigner_top #(
    .NUM_DOMAINS (NUM_DOMAINS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mmca_checker #(
    .NUM_DOMAINS (NUM_DOMAINS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .errors_o (mismatches),
    .due_o    (results_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input logic [ID_W-1:0] id, input logic has, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.domain_id   = id;
    in_ch.has_domain  = has;
    in_ch.last_domain = last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Send one item as a shuffled id list with duplicates and ignored ids mixed in
  task automatic send_list(input logic [NUM_DOMAINS-1:0] mask);
    logic [ID_W-1:0] ids [$];
    logic [ID_W-1:0] tmp;
    int unsigned     pick;
    logic            tail_noise;
    for (int b = 0; b < NUM_DOMAINS; b++)
      if (mask[b]) ids.insert(ids.size(), ID_W'(b));
    if (ids.size() > 0 && $urandom_range(0, 3) == 0)
      ids.insert(ids.size(), ids[$urandom_range(0, ids.size() - 1)]);
    for (int k = ids.size() - 1; k > 0; k--) begin
      pick      = $urandom_range(0, k);
      tmp       = ids[k];
      ids[k]    = ids[pick];
      ids[pick] = tmp;
    end
    tail_noise = (ids.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (ids[k]) begin
      if ($urandom_range(0, 5) == 0)
        send_request(ID_W'($urandom_range(0, 15)), 1'b0, 1'b0);
      send_request(ids[k], 1'b1, !tail_noise && (k == ids.size() - 1));
    end
    if (tail_noise)
      send_request(ID_W'($urandom_range(0, 15)), 1'b0, 1'b1);
  endtask

  // Hold the sender until every due result has been taken
  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [NUM_DOMAINS-1:0] mask;
    int unsigned            roll;
    int unsigned            slot;
    logic                   drained_once;
    in_ch.valid       = 1'b0;
    in_ch.domain_id   = '0;
    in_ch.has_domain  = 1'b0;
    in_ch.last_domain = 1'b0;
    out_ch.ready      = 1'b0;
    src_idle_pct      = 17;
    snk_idle_pct      = 79;
    drained_once      = 1'b0;
    rst_ni            = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty list, both extreme ids, duplicates, ignored ids, hits, then fill
    known_masks[0] = '0;
    known_masks[1] = NUM_DOMAINS'(1) << 15;
    known_masks[2] = NUM_DOMAINS'(1);
    known_masks[3] = (NUM_DOMAINS'(1) << 3) | (NUM_DOMAINS'(1) << 12);
    send_request(ID_W'(0), 1'b0, 1'b1);
    send_request(ID_W'(15), 1'b1, 1'b1);
    send_request(ID_W'(0), 1'b1, 1'b1);
    send_request(ID_W'(3), 1'b1, 1'b0);
    send_request(ID_W'(3), 1'b1, 1'b0);
    send_request(ID_W'(9), 1'b0, 1'b0);
    send_request(ID_W'(12), 1'b1, 1'b1);
    send_request(ID_W'(5), 1'b0, 1'b1);
    send_request(ID_W'(12), 1'b1, 1'b0);
    send_request(ID_W'(3), 1'b1, 1'b0);
    send_request(ID_W'(7), 1'b0, 1'b1);
    // Fill the remaining entries with single domains
    slot = 4;
    for (int b = 1; b < 15; b++) begin
      if (b != 3 && b != 12) begin
        known_masks[slot] = NUM_DOMAINS'(1) << b;
        send_request(ID_W'(b), 1'b1, 1'b1);
        slot++;
      end
    end
    // New mask with the table full
    send_request(ID_W'(1), 1'b1, 1'b0);
    send_request(ID_W'(2), 1'b1, 1'b1);
    wait_results_drained();

    // Random: mostly stored masks at every depth, the rest mostly misses on a full table
    while (requests_sent < DIRECTED_COUNT + RANDOM_COUNT) begin
      if (requests_sent < DIRECTED_COUNT + RANDOM_COUNT / 3) begin
        src_idle_pct = 17;
        snk_idle_pct = 79;
      end else if (requests_sent < DIRECTED_COUNT + 2 * RANDOM_COUNT / 3) begin
        src_idle_pct = 79;
        snk_idle_pct = 17;
      end else begin
        if (!drained_once) begin
          wait_results_drained();
          drained_once = 1'b1;
        end
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      roll = $urandom_range(0, 9);
      if (roll < 7)
        mask = known_masks[$urandom_range(0, MAX_CLASSES - 1)];
      else if (roll == 7)
        mask = NUM_DOMAINS'($urandom & $urandom);
      else if (roll == 8)
        mask = NUM_DOMAINS'($urandom);
      else
        mask = '1;
      send_list(mask);
    end

    // Drain, then allow for a stray late result
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
